// ----- rtl/row_or_column_argmin_assert.svh -----
// assertion macros shared by the argmin rtl
`ifndef ROW_OR_COLUMN_ARGMIN_ASSERT_SVH
`define ROW_OR_COLUMN_ARGMIN_ASSERT_SVH

`ifndef SYNTHESIS

// property holds on every edge out of reset
`define RCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define RCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RCA_ASSERT(lbl, prop, msg)
`define RCA_ASSERT_IMP(lbl, ante, cons, msg)
`define RCA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/rca_pkg.sv -----
// types and constants of the row or column argmin block
`timescale 1ns / 1ps

package rca_pkg;

  localparam int MAX_DIM       = 256;
  localparam int VALUE_BITS    = 32;
  localparam int IDX_BITS      = 8;
  localparam int CFG_DATA_BITS = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int ADDR_BITS     = $clog2(MAX_DIM);
  localparam int DIM_BITS      = ADDR_BITS + 1;
  localparam int ENTRY_BITS    = VALUE_BITS + IDX_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS  = CFG_IDX_BITS'(2);

  localparam logic DIR_ROW = 1'b0;
  localparam logic DIR_COL = 1'b1;

  // position of one element and what it closes
  typedef struct packed {
    logic                dir;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                row_end;
    logic                mat_end;
    logic                first_row;
    logic                last_row;
  } rca_pos_t;

  // one entry of the column store
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] min_val;
    logic [IDX_BITS-1:0]          min_idx;
  } rca_entry_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] min_value;
    logic [IDX_BITS-1:0]          min_index;
    logic [IDX_BITS-1:0]          line_index;
    logic                         last;
  } rca_result_t;

endpackage

// ----- rtl/rca_if.sv -----
// stream and configuration interfaces of the argmin block
`timescale 1ns / 1ps

interface rca_in_if import rca_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface rca_out_if import rca_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] min_value;
  logic [IDX_BITS-1:0]          min_index;
  logic [IDX_BITS-1:0]          line_index;
  logic                         last;
  modport source (output valid, output min_value, output min_index, output line_index,
                  output last, input ready);
  modport sink (input valid, input min_value, input min_index, input line_index,
                input last, output ready);
endinterface

interface rca_cfg_if import rca_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rca_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module rca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rca_seq.sv -----
// configuration registers and matrix position counters
`timescale 1ns / 1ps
`include "row_or_column_argmin_assert.svh"

module rca_seq import rca_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_fire,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_fire,
  output rca_pos_t                 pos
);

  logic                     dir;
  logic [CFG_DATA_BITS-1:0] num_rows;
  logic [CFG_DATA_BITS-1:0] num_cols;
  logic [ADDR_BITS-1:0]     row_count;
  logic [ADDR_BITS-1:0]     col_count;
  logic [DIM_BITS-1:0]      rows;
  logic [DIM_BITS-1:0]      cols;
  logic                     cfg_known;

  // zero acts as one, anything above the store depth as the depth
  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [CFG_DATA_BITS-1:0] v);
    logic [DIM_BITS-1:0] d;
    if (v == '0) begin
      d = DIM_BITS'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DIM_BITS'(MAX_DIM);
    end else begin
      d = DIM_BITS'(v);
    end
    return d;
  endfunction

  always_comb begin
    rows          = eff_dim(num_rows);
    cols          = eff_dim(num_cols);
    pos.dir       = dir;
    pos.row       = IDX_BITS'(row_count);
    pos.col       = IDX_BITS'(col_count);
    pos.row_end   = (DIM_BITS'(col_count) + DIM_BITS'(1)) >= cols;
    pos.last_row  = (DIM_BITS'(row_count) + DIM_BITS'(1)) >= rows;
    pos.mat_end   = pos.row_end && pos.last_row;
    pos.first_row = (row_count == '0);
    cfg_known     = (cfg_index == REG_DIRECTION) || (cfg_index == REG_NUM_ROWS) ||
                    (cfg_index == REG_NUM_COLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir       <= DIR_ROW;
      num_rows  <= CFG_DATA_BITS'(1);
      num_cols  <= CFG_DATA_BITS'(1);
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_DIRECTION: dir <= cfg_data[0];
        REG_NUM_ROWS:  num_rows <= cfg_data;
        REG_NUM_COLS:  num_cols <= cfg_data;
        default: ;
      endcase
      // any known register write restarts the matrix
      if (cfg_known) begin
        row_count <= '0;
        col_count <= '0;
      end
    end else if (in_fire) begin
      if (pos.row_end) begin
        col_count <= '0;
        row_count <= pos.last_row ? '0 : row_count + ADDR_BITS'(1);
      end else begin
        col_count <= col_count + ADDR_BITS'(1);
      end
    end
  end

  `RCA_ASSERT(col_in_range, DIM_BITS'(col_count) < cols, "column count beyond matrix width")
  `RCA_ASSERT_IMP(mat_end_is_row_end, pos.mat_end, pos.row_end, "matrix end off a row end")
  `RCA_ASSERT_NEXT(wrap_after_matrix, in_fire && pos.mat_end && !cfg_fire,
                   row_count == '0 && col_count == '0, "counters did not wrap")

endmodule

// ----- rtl/rca_pipe.sv -----
// compare and update stage, store forwarding and output register
`timescale 1ns / 1ps
`include "row_or_column_argmin_assert.svh"

module rca_pipe import rca_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  rca_pos_t                     pos,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [ADDR_BITS-1:0]         rd_addr,
  input  logic [ENTRY_BITS-1:0]        rd_data,
  output logic                         wr_en,
  output logic [ADDR_BITS-1:0]         wr_addr,
  output logic [ENTRY_BITS-1:0]        wr_data,
  output logic                         stall,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rca_result_t                  out_data
);

  rca_pos_t                     s1_pos;
  logic                         s1_valid;
  logic signed [VALUE_BITS-1:0] s1_value;
  logic                         s1_result;
  logic                         s1_fire;
  logic                         fwd_hit;
  rca_entry_t                   fwd_entry;
  rca_entry_t                   col_old;
  rca_entry_t                   col_new;
  logic signed [VALUE_BITS-1:0] run_min;
  logic [IDX_BITS-1:0]          run_idx;
  logic signed [VALUE_BITS-1:0] row_min_next;
  logic [IDX_BITS-1:0]          row_idx_next;
  rca_result_t                  res_next;

  always_comb begin
    s1_result = (s1_pos.dir == DIR_COL) ? s1_pos.last_row : s1_pos.row_end;
    stall     = s1_valid && s1_result && out_valid && !out_ready;
    s1_fire   = s1_valid && !stall;

    // entry written on the same edge as this item's read comes from the forward register
    col_old = fwd_hit ? fwd_entry : rca_entry_t'(rd_data);
    if (s1_pos.first_row || (s1_value < col_old.min_val)) begin
      col_new.min_val = s1_value;
      col_new.min_idx = s1_pos.row;
    end else begin
      col_new = col_old;
    end

    if ((s1_pos.col == '0) || (s1_value < run_min)) begin
      row_min_next = s1_value;
      row_idx_next = s1_pos.col;
    end else begin
      row_min_next = run_min;
      row_idx_next = run_idx;
    end

    wr_en   = s1_fire && (s1_pos.dir == DIR_COL);
    wr_addr = s1_pos.col[ADDR_BITS-1:0];
    wr_data = ENTRY_BITS'(col_new);

    if (s1_pos.dir == DIR_COL) begin
      res_next.min_value  = col_new.min_val;
      res_next.min_index  = col_new.min_idx;
      res_next.line_index = s1_pos.col;
    end else begin
      res_next.min_value  = row_min_next;
      res_next.min_index  = row_idx_next;
      res_next.line_index = s1_pos.row;
    end
    res_next.last = s1_pos.mat_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (!stall) begin
        s1_valid <= in_fire;
      end
      if (s1_fire && s1_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
    if (in_fire) begin
      s1_pos    <= pos;
      s1_value  <= value;
      fwd_entry <= col_new;
    end
    if (s1_fire && (s1_pos.dir == DIR_ROW)) begin
      run_min <= row_min_next;
      run_idx <= row_idx_next;
    end
    if (s1_fire && s1_result) begin
      out_data <= res_next;
    end
  end

  `RCA_ASSERT_IMP(write_needs_item, wr_en, s1_valid && s1_pos.dir == DIR_COL,
                  "store written without a column item")
  `RCA_ASSERT_NEXT(forward_same_entry, in_fire && wr_en && (wr_addr == rd_addr), fwd_hit,
                   "same-entry read missed the forward path")
  `RCA_ASSERT_IMP(no_accept_on_stall, stall, !in_fire, "item taken while stage one stalled")

endmodule

// ----- rtl/row_or_column_argmin.sv -----
// top level of the row or column argmin block
//
//   channel  dir  transfer when          payload
//   values   in   valid && ready         value (signed)
//   minima   out  valid && ready         min_value, min_index, line_index, last
//   cfg      in   valid && ready         index, data (ready always high)
//
// one element a cycle unless stalled; results go via stage one and out_data
// the column store ram is read on accept and written back from stage one
// back-to-back hits on one column entry take the forwarded value
// rst is synchronous; counters and valids clear, the column store needs no clearing
// values.ready drops only while a finished result waits behind an untaken one
`timescale 1ns / 1ps

module row_or_column_argmin import rca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rca_cfg_if.sink    cfg,
  rca_in_if.sink     values,
  rca_out_if.source  minima
);

  rca_pos_t              pos;
  logic                  in_fire;
  logic                  stall;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  out_valid;
  rca_result_t           out_data;

  assign cfg.ready    = 1'b1;
  assign values.ready = !stall;
  assign in_fire      = values.valid && !stall;
  assign rd_addr      = pos.col[ADDR_BITS-1:0];

  assign minima.valid      = out_valid;
  assign minima.min_value  = out_data.min_value;
  assign minima.min_index  = out_data.min_index;
  assign minima.line_index = out_data.line_index;
  assign minima.last       = out_data.last;

  rca_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .in_fire   (in_fire),
    .pos       (pos)
  );

  rca_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_DIM)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rca_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .pos       (pos),
    .value     (values.value),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .stall     (stall),
    .out_valid (out_valid),
    .out_ready (minima.ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/argmin_checker.sv -----
// watches the argmin channels, predicts every minimum and compares it with what leaves the block
`timescale 1ns / 1ps

module argmin_checker import rca_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                         value_valid,
  input  logic                         value_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         minima_valid,
  input  logic                         minima_ready,
  input  logic signed [VALUE_BITS-1:0] min_value,
  input  logic [IDX_BITS-1:0]          min_index,
  input  logic [IDX_BITS-1:0]          line_index,
  input  logic                         last,
  output int                           pending,
  output int                           failures
);

  logic                         dir_q;
  logic [CFG_DATA_BITS-1:0]     rows_q;
  logic [CFG_DATA_BITS-1:0]     cols_q;
  logic [IDX_BITS-1:0]          row_at;
  logic [IDX_BITS-1:0]          col_at;
  logic signed [VALUE_BITS-1:0] row_min;
  logic [IDX_BITS-1:0]          row_min_at;
  logic signed [VALUE_BITS-1:0] col_min [MAX_DIM];
  logic [IDX_BITS-1:0]          col_min_at [MAX_DIM];
  rca_result_t                  minima_due [$];
  int                           err_count = 0;

  // a size of zero counts as one, anything past the store depth as the full depth
  function automatic int span(input logic [CFG_DATA_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void predict_minimum(input logic signed [VALUE_BITS-1:0] x);
    int          n_rows;
    int          n_cols;
    int          r;
    int          c;
    int          k;
    bit          row_end;
    bit          mat_end;
    rca_result_t res;
    n_rows  = span(rows_q);
    n_cols  = span(cols_q);
    r       = int'(row_at);
    c       = int'(col_at);
    row_end = (c + 1 >= n_cols);
    mat_end = row_end && (r + 1 >= n_rows);
    if (dir_q == DIR_ROW) begin
      if (c == 0 || x < row_min) begin
        row_min    = x;
        row_min_at = IDX_BITS'(c);
      end
      if (row_end) begin
        res = '{min_value: row_min, min_index: row_min_at, line_index: IDX_BITS'(r),
                last: mat_end};
        minima_due.push_back(res);
      end
    end else begin
      k = (c >= MAX_DIM) ? MAX_DIM - 1 : c;
      if (r == 0 || x < col_min[k]) begin
        col_min[k]    = x;
        col_min_at[k] = IDX_BITS'(r);
      end
      if (r + 1 >= n_rows) begin
        res = '{min_value: col_min[k], min_index: col_min_at[k], line_index: IDX_BITS'(c),
                last: mat_end};
        minima_due.push_back(res);
      end
    end
    if (row_end) begin
      col_at = '0;
      row_at = mat_end ? '0 : IDX_BITS'(r + 1);
    end else begin
      col_at = IDX_BITS'(c + 1);
    end
  endfunction

  always @(posedge clk) begin
    rca_result_t want;
    bit          known;
    if (rst) begin
      dir_q      = DIR_ROW;
      rows_q     = CFG_DATA_BITS'(1);
      cols_q     = CFG_DATA_BITS'(1);
      row_at     = '0;
      col_at     = '0;
      row_min    = '0;
      row_min_at = '0;
      for (int i = 0; i < MAX_DIM; i++) begin
        col_min[i]    = '0;
        col_min_at[i] = '0;
      end
      minima_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        known = 1'b1;
        case (cfg_index)
          REG_DIRECTION: dir_q  = cfg_data[0];
          REG_NUM_ROWS:  rows_q = cfg_data;
          REG_NUM_COLS:  cols_q = cfg_data;
          default:       known  = 1'b0;
        endcase
        // any known register write restarts the matrix
        if (known) begin
          row_at = '0;
          col_at = '0;
        end
      end
      if (value_valid && value_ready) predict_minimum(value);
      if (minima_valid && minima_ready) begin
        if (minima_due.size() == 0) begin
          $error("result with no element waiting for it: min_value %0d line_index %0d",
                 min_value, line_index);
          err_count++;
        end else begin
          want = minima_due.pop_front();
          if (min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, min_value);
            err_count++;
          end
          if (min_index !== want.min_index) begin
            $error("min_index: expected %0d, got %0d", want.min_index, min_index);
            err_count++;
          end
          if (line_index !== want.line_index) begin
            $error("line_index: expected %0d, got %0d", want.line_index, line_index);
            err_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            err_count++;
          end
        end
      end
    end
    pending  <= minima_due.size();
    failures <= err_count;
  end

endmodule

// ----- tb/tb_row_or_column_argmin.sv -----
// stimulus and verdict for the row or column argmin block
`timescale 1ns / 1ps

module tb_row_or_column_argmin import rca_pkg::*; ();

  localparam int RANDOM_ITEMS = 825;
  localparam int PHASE_ITEMS  = 290;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [CFG_IDX_BITS-1:0]  REG_SPARE = CFG_IDX_BITS'(3);
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic clk;
  logic rst;
  int   pending;
  int   failures;
  int   cycles = 0;
  int   sent = 0;
  int   src_gap_pct = 0;
  int   sink_stall_pct = 0;

  logic                     cur_dir;
  logic [CFG_DATA_BITS-1:0] cur_rows;
  logic [CFG_DATA_BITS-1:0] cur_cols;

  rca_cfg_if cfg_bus ();
  rca_in_if  value_bus ();
  rca_out_if minima_bus ();

  row_or_column_argmin i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .values (value_bus),
    .minima (minima_bus)
  );

  argmin_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_bus.valid),
    .cfg_ready    (cfg_bus.ready),
    .cfg_index    (cfg_bus.index),
    .cfg_data     (cfg_bus.data),
    .value_valid  (value_bus.valid),
    .value_ready  (value_bus.ready),
    .value        (value_bus.value),
    .minima_valid (minima_bus.valid),
    .minima_ready (minima_bus.ready),
    .min_value    (minima_bus.min_value),
    .min_index    (minima_bus.min_index),
    .line_index   (minima_bus.line_index),
    .last         (minima_bus.last),
    .pending      (pending),
    .failures     (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    minima_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      minima_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one element transfer; valid stays high so back-to-back elements need no toggle
  task automatic send(input logic signed [VALUE_BITS-1:0] v);
    if (sent < PHASE_ITEMS) begin
      src_gap_pct    = 14;
      sink_stall_pct = 61;
    end else if (sent < 2 * PHASE_ITEMS) begin
      src_gap_pct    = 61;
      sink_stall_pct = 14;
    end else begin
      src_gap_pct    = 0;
      sink_stall_pct = 0;
    end
    while ($urandom_range(99) < src_gap_pct) begin
      value_bus.valid <= 1'b0;
      @(posedge clk);
    end
    value_bus.valid <= 1'b1;
    value_bus.value <= v;
    @(posedge clk);
    while (!value_bus.ready) @(posedge clk);
    sent++;
  endtask

  // hold the stream until every minimum has left and the pipeline is empty
  task automatic drain();
    value_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic setup(input logic dir, input logic [CFG_DATA_BITS-1:0] rows,
                       input logic [CFG_DATA_BITS-1:0] cols);
    drain();
    put_reg(REG_DIRECTION, CFG_DATA_BITS'(dir));
    put_reg(REG_NUM_ROWS, rows);
    put_reg(REG_NUM_COLS, cols);
    cfg_bus.valid <= 1'b0;
    cur_dir  = dir;
    cur_rows = rows;
    cur_cols = cols;
  endtask

  task automatic poke(input logic [CFG_IDX_BITS-1:0] idx,
                      input logic [CFG_DATA_BITS-1:0] d);
    drain();
    put_reg(idx, d);
    cfg_bus.valid <= 1'b0;
  endtask

  // mid-matrix hold-off, optionally with an ignored write or a same-value rewrite
  task automatic pause_mid_matrix();
    case ($urandom_range(3))
      0: drain();
      1: poke(REG_SPARE, CFG_DATA_BITS'($urandom));
      2: poke(REG_DIRECTION, CFG_DATA_BITS'(cur_dir));
      default: begin
        if ($urandom_range(1) == 0) poke(REG_NUM_ROWS, cur_rows);
        else poke(REG_NUM_COLS, cur_cols);
      end
    endcase
  endtask

  // extremes, small values for plenty of ties, and full-range noise
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int t;
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: begin
        t = $urandom_range(6);
        return VALUE_BITS'(t - 3);
      end
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_dim();
    if ($urandom_range(14) == 0) return '0;
    return CFG_DATA_BITS'($urandom_range(1, 6));
  endfunction

  initial begin
    int rnd_sent;
    int seg;
    int n;
    int r_eff;
    int c_eff;
    logic [CFG_DATA_BITS-1:0] rows;
    logic [CFG_DATA_BITS-1:0] cols;
    rst              <= 1'b1;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_DIRECTION;
    cfg_bus.data     <= '0;
    value_bus.valid  <= 1'b0;
    value_bus.value  <= '0;
    cur_dir  = DIR_ROW;
    cur_rows = CFG_DATA_BITS'(1);
    cur_cols = CFG_DATA_BITS'(1);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape: 1x1 in row mode, every element is a whole matrix
    send(VAL_MIN);
    send(VAL_MAX);
    send(0);
    send(-1);

    // zero rows act as one; ties keep the earliest column
    setup(DIR_ROW, '0, CFG_DATA_BITS'(3));
    send(VAL_MAX);
    send(VAL_MIN);
    send(VAL_MIN);
    send(7);
    send(7);
    send(7);

    // hold-off mid-row, ignored register index, then a same-value rewrite that restarts
    setup(DIR_ROW, CFG_DATA_BITS'(2), CFG_DATA_BITS'(3));
    send(3);
    send(-2);
    drain();
    poke(REG_SPARE, CFG_DATA_BITS'(5));
    send(-2);
    send(5);
    poke(REG_NUM_COLS, CFG_DATA_BITS'(3));
    send(1);
    send(2);
    send(0);

    // column mode with a tie down the second column
    setup(DIR_COL, CFG_DATA_BITS'(3), CFG_DATA_BITS'(2));
    send(4);
    send(-1);
    send(-1);
    send(8);
    send(-5);
    send(-1);

    rnd_sent = 0;
    seg      = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      seg++;
      if (seg == 2) begin
        // rows past the store depth act as the full depth
        setup(DIR_ROW, '1, CFG_DATA_BITS'(1));
        n = MAX_DIM;
      end else if (seg == 5) begin
        setup(DIR_COL, CFG_DATA_BITS'(1), CFG_DATA_BITS'(MAX_DIM));
        n = 40;
      end else begin
        rows = pick_dim();
        cols = pick_dim();
        setup(logic'($urandom_range(1)), rows, cols);
        r_eff = (rows == 0) ? 1 : int'(rows);
        c_eff = (cols == 0) ? 1 : int'(cols);
        n = r_eff * c_eff * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) n += $urandom_range(0, r_eff * c_eff - 1);
      end
      repeat (n) begin
        send(pick_value());
        rnd_sent++;
        if ($urandom_range(24) == 0) pause_mid_matrix();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
